### rtl/core/cplf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and level mapping for the CPU priority level finder.
// No dependencies; used by the core top level.
package cplf_pkg;

	localparam int NUM_CPUS      = 64;
	localparam int NUM_LEVELS    = 102;
	localparam int RT_LEVELS     = 100;
	localparam int IDLE_PRIORITY = 140;

	localparam int CPU_W  = 6;   // cpu_index field
	localparam int PRIO_W = 9;   // raw_priority field, signed
	localparam int MASK_W = 64;  // allowed_cpus / lowest_cpus fields
	localparam int LVL_W  = 7;   // level code, match_level field

	localparam int CPU_AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int LVL_AW = $clog2(NUM_LEVELS);

	localparam logic [LVL_W-1:0] LEVEL_INVALID = {LVL_W{1'b1}};

	// transaction kinds carried on s_tuser
	localparam logic KIND_SET  = 1'b0;
	localparam logic KIND_FIND = 1'b1;

	// raw priority -> level code
	function automatic logic [LVL_W-1:0] map_level(input logic signed [PRIO_W-1:0] prio);
		int p;
		int lvl;
		p = int'(prio);
		if (p < 0) begin
			return LEVEL_INVALID;
		end
		if (p == IDLE_PRIORITY) begin
			lvl = 0;
		end else if (p >= RT_LEVELS) begin
			lvl = 1;
		end else begin
			lvl = RT_LEVELS + 1 - p;
		end
		if (lvl >= NUM_LEVELS) begin
			return LEVEL_INVALID;
		end
		return LVL_W'(lvl);
	endfunction

endpackage

### rtl/core/cplf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cplf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/cpu_priority_level_finder_core.sv
`timescale 1ns / 1ps
// CPU priority level finder core: per-CPU level table plus per-level CPU masks.
// Set: cpu read, new-level add, old-level remove, a step left out when it has nothing to do;
// find: scans the levels below the task level, one level mask read per cycle from the mask RAM.
// The next transaction is taken in the cycle the result goes valid, even while it waits.
// One transaction is worked on at a time.
// Reset (arst_n low) clears the per-entry valid bits at once: no clearing pass.
module cpu_priority_level_finder_core (
	input  logic        clk,
	input  logic        arst_n,
	// input transaction
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // cpu_index[5:0], raw_priority[14:6], allowed_cpus[78:15], 0
	input  logic        s_tuser,   // kind: 0 set, 1 find
	// result transaction
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // lowest_cpus[63:0], match_level[70:64], 0
	output logic        m_tuser    // found
);
	import cplf_pkg::*;

	// one-hot sequencer
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SET_OLD = 6'b000010,
		ST_SET_ADD = 6'b000100,
		ST_SET_DEL = 6'b001000,
		ST_FIND    = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t state_q;

	// input fields
	logic [CPU_W-1:0]         in_cpu;
	logic signed [PRIO_W-1:0] in_prio;
	logic [MASK_W-1:0]        in_allowed;
	assign in_cpu     = s_tdata[CPU_W-1:0];
	assign in_prio    = s_tdata[CPU_W+PRIO_W-1:CPU_W];
	assign in_allowed = s_tdata[CPU_W+PRIO_W+MASK_W-1:CPU_W+PRIO_W];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// captured transaction
	logic [CPU_W-1:0]  cpu_q;
	logic [LVL_W-1:0]  lvl_q;      // new level (set) or task level (find)
	logic [LVL_W-1:0]  old_q;      // previous level of the CPU (set)
	logic [MASK_W-1:0] allowed_q;

	// working result and output register
	logic              res_found_q;
	logic [MASK_W-1:0] res_cpus_q;
	logic [LVL_W-1:0]  res_lvl_q;
	logic              out_vld_q;
	logic              out_found_q;
	logic [MASK_W-1:0] out_cpus_q;
	logic [LVL_W-1:0]  out_lvl_q;

	// scan state
	logic [LVL_W-1:0] idx_q;     // next level to read
	logic [LVL_W-1:0] idx_s1;    // level whose mask is on the RAM output
	logic             pend_q;    // a scan read is on the RAM output

	// valid bits stand in for the reset of both tables
	logic [NUM_CPUS-1:0]   cpu_vld_q;
	logic [NUM_LEVELS-1:0] mask_vld_q;
	logic                  rd_vld_s1;

	// level table: one entry per CPU
	logic              cpu_re, cpu_we;
	logic [LVL_W-1:0]  cpu_rdata;
	// mask table: one entry per level; count not kept, it is zero exactly when the mask is
	logic              mask_re, mask_we;
	logic [LVL_AW-1:0] mask_raddr, mask_waddr;
	logic [MASK_W-1:0] mask_wdata, mask_rdata;

	cplf_ram #(.WIDTH(LVL_W), .DEPTH(NUM_CPUS)) u_cpu_level (
		.clk   (clk),
		.we    (cpu_we),
		.waddr (cpu_q[CPU_AW-1:0]),
		.wdata (lvl_q),
		.re    (cpu_re),
		.raddr (in_cpu[CPU_AW-1:0]),
		.rdata (cpu_rdata)
	);

	cplf_ram #(.WIDTH(MASK_W), .DEPTH(NUM_LEVELS)) u_level_mask (
		.clk   (clk),
		.we    (mask_we),
		.waddr (mask_waddr),
		.wdata (mask_wdata),
		.re    (mask_re),
		.raddr (mask_raddr),
		.rdata (mask_rdata)
	);

	// decoded values
	logic [LVL_W-1:0]  old_lvl;
	logic              new_ok, old_ok, old_q_ok, same_lvl;
	logic [MASK_W-1:0] cur_mask, cpu_bit, hit_cpus;
	logic              hit;
	logic              more;

	assign old_lvl  = cpu_vld_q[cpu_q[CPU_AW-1:0]] ? cpu_rdata : LEVEL_INVALID;
	assign new_ok   = (int'(lvl_q) < NUM_LEVELS);
	assign old_ok   = (int'(old_lvl) < NUM_LEVELS);
	assign old_q_ok = (int'(old_q) < NUM_LEVELS);
	assign same_lvl = (old_lvl == lvl_q);
	assign cur_mask = rd_vld_s1 ? mask_rdata : '0;
	assign cpu_bit  = MASK_W'(1) << cpu_q;
	assign hit_cpus = cur_mask & allowed_q;
	assign hit      = pend_q && (hit_cpus != '0);
	assign more     = (idx_q < lvl_q);

	// RAM port control
	always_comb begin
		cpu_re     = accept && (s_tuser == KIND_SET);
		cpu_we     = 1'b0;
		mask_re    = 1'b0;
		mask_raddr = '0;
		mask_we    = 1'b0;
		mask_waddr = '0;
		mask_wdata = '0;
		unique case (state_q)
			ST_SET_OLD: begin
				if (!same_lvl) begin
					cpu_we = 1'b1;
					if (new_ok) begin
						mask_re    = 1'b1;
						mask_raddr = lvl_q[LVL_AW-1:0];
					end else if (old_ok) begin
						mask_re    = 1'b1;
						mask_raddr = old_lvl[LVL_AW-1:0];
					end
				end
			end
			ST_SET_ADD: begin
				// add to the new level first, read the old one meanwhile
				mask_we    = 1'b1;
				mask_waddr = lvl_q[LVL_AW-1:0];
				mask_wdata = cur_mask | cpu_bit;
				if (old_q_ok) begin
					mask_re    = 1'b1;
					mask_raddr = old_q[LVL_AW-1:0];
				end
			end
			ST_SET_DEL: begin
				mask_we    = 1'b1;
				mask_waddr = old_q[LVL_AW-1:0];
				mask_wdata = cur_mask & ~cpu_bit;
			end
			ST_FIND: begin
				if (!hit && more) begin
					mask_re    = 1'b1;
					mask_raddr = idx_q[LVL_AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_vld_q  <= 1'b0;
			pend_q     <= 1'b0;
			cpu_vld_q  <= '0;
			mask_vld_q <= '0;
		end else begin
			// in ST_DONE the output register is reloaded below
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				out_vld_q <= 1'b0;
			end
			if (cpu_we) begin
				cpu_vld_q[cpu_q[CPU_AW-1:0]] <= 1'b1;
			end
			if (mask_we) begin
				mask_vld_q[mask_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (accept) begin
						if (s_tuser == KIND_SET) begin
							state_q <= (int'(in_cpu) < NUM_CPUS) ? ST_SET_OLD : ST_DONE;
						end else begin
							state_q <= (int'(map_level(in_prio)) < RT_LEVELS) ? ST_FIND
							                                                   : ST_DONE;
						end
					end
				end
				ST_SET_OLD: begin
					if (same_lvl) begin
						state_q <= ST_DONE;
					end else if (new_ok) begin
						state_q <= ST_SET_ADD;
					end else if (old_ok) begin
						state_q <= ST_SET_DEL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SET_ADD: begin
					state_q <= old_q_ok ? ST_SET_DEL : ST_DONE;
				end
				ST_SET_DEL: begin
					state_q <= ST_DONE;
				end
				ST_FIND: begin
					priority if (hit) begin
						state_q <= ST_DONE;
					end else if (more) begin
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;   // last read came back empty
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_vld_q || m_tready) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cpu_q       <= in_cpu;
			lvl_q       <= map_level(in_prio);
			allowed_q   <= in_allowed;
			idx_q       <= '0;
			res_found_q <= 1'b0;
			res_cpus_q  <= '0;
			res_lvl_q   <= '0;
		end
		if (state_q == ST_SET_OLD) begin
			old_q <= old_lvl;
		end
		if (mask_re) begin
			rd_vld_s1 <= mask_vld_q[mask_raddr];
			idx_s1    <= idx_q;
		end
		if (state_q == ST_FIND) begin
			if (hit) begin
				res_found_q <= 1'b1;
				res_cpus_q  <= hit_cpus;
				res_lvl_q   <= idx_s1;
			end else if (more) begin
				idx_q <= idx_q + LVL_W'(1);
			end
		end
		if (state_q == ST_DONE && (!out_vld_q || m_tready)) begin
			out_found_q <= res_found_q;
			out_cpus_q  <= res_cpus_q;
			out_lvl_q   <= res_lvl_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {1'b0, out_lvl_q, out_cpus_q};

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("core ready right after taking a transaction");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[MASK_W-1:0] != '0)
		else $error("found result with empty cpu mask");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found result carries data");

	a_match_below_rt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> int'(m_tdata[MASK_W+LVL_W-1:MASK_W]) < RT_LEVELS)
		else $error("match level at or above the RT range");

endmodule

### test/cplf_level_checker.sv
`timescale 1ns / 1ps
// Result checker for the CPU priority level finder core: watches both streams,
// predicts every result from its own level table and counts mismatches. Uses cplf_pkg.
module cplf_level_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,   // cpu_index[5:0], raw_priority[14:6], allowed_cpus[78:15], 0
	input  logic        s_tuser,   // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // lowest_cpus[63:0], match_level[70:64], 0
	input  logic        m_tuser,   // found
	output int          fail_count,
	output int          pending
);
	import cplf_pkg::*;

	typedef struct packed {
		logic              found;
		logic [LVL_W-1:0]  level;
		logic [MASK_W-1:0] cpus;
	} search_result_t;

	// CPUs that exist at all
	localparam logic [MASK_W-1:0] CPU_SPAN = (NUM_CPUS >= MASK_W) ? {MASK_W{1'b1}} :
		((MASK_W'(1) << NUM_CPUS) - 1'b1);

	logic [LVL_W-1:0]  cpu_lvl  [NUM_CPUS];
	logic [MASK_W-1:0] lvl_cpus [NUM_LEVELS];
	logic [LVL_W-1:0]  lvl_pop  [NUM_LEVELS];
	search_result_t    expected_results [$];

	function automatic logic [LVL_W-1:0] prio_to_level(input logic signed [PRIO_W-1:0] prio);
		int p;
		int lvl;
		p = prio;
		if (p < 0) begin
			return LEVEL_INVALID;
		end
		case (1'b1)
			(p == IDLE_PRIORITY): lvl = 0;
			(p >= RT_LEVELS):     lvl = 1;
			default:              lvl = RT_LEVELS + 1 - p;
		endcase
		return (lvl >= NUM_LEVELS) ? LEVEL_INVALID : LVL_W'(lvl);
	endfunction

	// Applies one transaction to the level table and returns what the core must answer.
	task automatic predict_level_search(input logic kind, input logic [CPU_W-1:0] cpu,
			input logic signed [PRIO_W-1:0] prio, input logic [MASK_W-1:0] allowed,
			output search_result_t res);
		logic [LVL_W-1:0]  new_lvl;
		logic [LVL_W-1:0]  old_lvl;
		logic [MASK_W-1:0] hit;
		res = '0;
		new_lvl = prio_to_level(prio);
		if (kind == KIND_SET) begin
			if (int'(cpu) >= NUM_CPUS) begin
				return;
			end
			old_lvl = cpu_lvl[cpu];
			if (new_lvl == old_lvl) begin
				return;
			end
			// add to the new level first, then drop from the old one
			if (int'(new_lvl) < NUM_LEVELS) begin
				lvl_cpus[new_lvl][cpu] = 1'b1;
				lvl_pop[new_lvl] = lvl_pop[new_lvl] + 1'b1;
			end
			if (int'(old_lvl) < NUM_LEVELS) begin
				lvl_pop[old_lvl] = lvl_pop[old_lvl] - 1'b1;
				lvl_cpus[old_lvl][cpu] = 1'b0;
			end
			cpu_lvl[cpu] = new_lvl;
			return;
		end
		// tasks at RT level or above (invalid too) never find anything
		if (int'(new_lvl) >= RT_LEVELS) begin
			return;
		end
		for (int i = 0; i < int'(new_lvl) && i < NUM_LEVELS; i++) begin
			if (!res.found && lvl_pop[i] != '0) begin
				hit = allowed & lvl_cpus[i] & CPU_SPAN;
				if (hit != '0) begin
					res.found = 1'b1;
					res.cpus  = hit;
					res.level = LVL_W'(i);
				end
			end
		end
	endtask

	always @(posedge clk) begin : watch
		search_result_t want;
		search_result_t got;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CPUS; c++) begin
				cpu_lvl[c] = LEVEL_INVALID;
			end
			for (int l = 0; l < NUM_LEVELS; l++) begin
				lvl_cpus[l] = '0;
				lvl_pop[l]  = '0;
			end
			expected_results.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// results leave in order: a result leaving now belongs to an older input
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.level = m_tdata[70:64];
				got.cpus  = m_tdata[63:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got found=%0b level=%0d cpus=%h",
						$time, got.found, got.level, got.cpus);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (got.found !== want.found) begin
						$display("%0t: found mismatch: expected %0b, got %0b",
							$time, want.found, got.found);
						errs++;
					end
					if (got.level !== want.level) begin
						$display("%0t: match_level mismatch: expected %0d, got %0d",
							$time, want.level, got.level);
						errs++;
					end
					if (got.cpus !== want.cpus) begin
						$display("%0t: lowest_cpus mismatch: expected %h, got %h",
							$time, want.cpus, got.cpus);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_level_search(s_tuser, s_tdata[5:0], s_tdata[14:6], s_tdata[78:15], want);
				expected_results.push_back(want);
			end
			fail_count <= fail_count + errs;
			pending    <= expected_results.size();
		end
	end

endmodule

### test/tb_cpu_priority_level_finder_core.sv
`timescale 1ns / 1ps
// Testbench top for the CPU priority level finder core: directed and random set/find
// transactions with random idling on both streams. Depends on cplf_pkg and cplf_level_checker.
module tb_cpu_priority_level_finder_core;
	import cplf_pkg::*;

	localparam int ITEMS          = 1500;
	// worst gap between transactions: sender gap + find scan + sink stall
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 200;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tuser;

	int   fail_count;
	int   pending;
	int   quiet_cycles;
	logic steady;   // both sides run without idling while set

	cpu_priority_level_finder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cplf_level_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Presents one transaction after a random gap (none while steady) and returns at the edge that takes it.
	task automatic send_op(input logic kind, input logic [CPU_W-1:0] cpu,
			input logic signed [PRIO_W-1:0] prio, input logic [MASK_W-1:0] allowed);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, allowed, prio, cpu};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Result sink: random stall before each result (none while steady)
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Watchdog: too long with no transaction on either stream
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic                     kind;
		logic [CPU_W-1:0]         cpu;
		logic signed [PRIO_W-1:0] prio;
		logic [MASK_W-1:0]        allowed;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = KIND_SET;
		steady   = 1'b0;
		arst_n   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_op(KIND_FIND, 0, 2, '1);            // all CPUs invalid: nothing to find
		send_op(KIND_SET, 0, 140, '0);           // idle -> level 0
		send_op(KIND_SET, 63, 120, '1);          // normal -> level 1
		send_op(KIND_SET, 1, 99, '0);            // lowest RT value -> level 2
		send_op(KIND_SET, 2, 0, '0);             // highest RT -> top level
		send_op(KIND_SET, 3, 255, '0);           // above idle maps to normal
		send_op(KIND_SET, 4, -256, '0);          // other negative: stays invalid
		send_op(KIND_SET, 5, 50, '0);
		send_op(KIND_SET, 5, -2, '0);            // back to invalid, drops out of its level
		send_op(KIND_SET, 63, 110, '0);          // same level again: no change
		send_op(KIND_FIND, 63, 2, '1);           // hits the idle CPU at level 0
		send_op(KIND_FIND, 0, 2, 64'h8000_0000_0000_0000);  // level 1 via CPU 63
		send_op(KIND_FIND, 0, 140, '1);          // idle task: no level below it
		send_op(KIND_FIND, 0, 0, '1);            // task above RT range: not found
		send_op(KIND_FIND, 0, 1, '1);            // task at RT level exactly: not found
		send_op(KIND_FIND, 0, 100, '1);          // normal task, idle CPU below
		send_op(KIND_FIND, 0, -1, '1);           // invalid task
		send_op(KIND_FIND, 0, 2, '0);            // empty allowed mask
		send_op(KIND_FIND, 0, 99, 64'h2);        // CPU 1 sits at the task's own level
		send_op(KIND_FIND, 0, 98, 64'h2);        // one level higher: CPU 1 found
		send_op(KIND_SET, 1, 1, '0);             // level 100
		send_op(KIND_SET, 2, -1, '0);            // top level back to invalid
		send_op(KIND_FIND, 0, 255, 64'h5555_aaaa_0f0f_f0f0);

		// --- random part: mostly well-formed priorities, some noise ---
		for (int n = 0; n < ITEMS; n++) begin
			if (n % 50 == 0) begin
				steady <= ($urandom_range(0, 3) == 0);
			end
			kind = ($urandom_range(0, 1) == 0) ? KIND_SET : KIND_FIND;
			cpu  = CPU_W'($urandom_range(0, 63));
			if (kind == KIND_SET) begin
				case ($urandom_range(0, 19))
					0, 1:          prio = -1;
					2, 3:          prio = PRIO_W'(IDLE_PRIORITY);
					4, 5, 6:       prio = PRIO_W'($urandom_range(100, 139));
					7:             prio = PRIO_W'($urandom_range(141, 255));
					8:             prio = PRIO_W'(-int'($urandom_range(2, 256)));
					9:             prio = PRIO_W'($urandom);
					default:       prio = PRIO_W'($urandom_range(0, 99));
				endcase
			end else begin
				case ($urandom_range(0, 9))
					0:             prio = PRIO_W'($urandom_range(0, 1));
					1:             prio = PRIO_W'($urandom_range(100, 140));
					2:             prio = ($urandom_range(0, 1) == 0) ? -1 : PRIO_W'($urandom);
					default:       prio = PRIO_W'($urandom_range(2, 99));   // deep scans
				endcase
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: allowed = {$urandom, $urandom};
				4, 5:       allowed = MASK_W'(1) << $urandom_range(0, 63);
				6:          allowed = (MASK_W'(1) << $urandom_range(0, 63)) |
				                      (MASK_W'(1) << $urandom_range(0, 63)) |
				                      (MASK_W'(1) << $urandom_range(0, 63));
				7:          allowed = '1;
				8:          allowed = '0;
				default:    allowed = {$urandom, $urandom} & {$urandom, $urandom};
			endcase
			send_op(kind, cpu, prio, allowed);
		end
		s_tvalid <= 1'b0;

		// drain: let the checker see the last acceptance, then wait out the scan latency
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### cpu_priority_level_finder_core.f
rtl/core/cplf_pkg.sv
rtl/core/cplf_ram.sv
rtl/core/cpu_priority_level_finder_core.sv
test/cplf_level_checker.sv
test/tb_cpu_priority_level_finder_core.sv
